### src/cbcr_pkg.sv
package cbcr_pkg;

    // Per-item flags carried alongside the geometry through the pipeline
    typedef struct packed {
        logic pre;     // both offset magnitudes are within the doubled radius
        logic neg_x;   // x offset is negative
        logic neg_y;   // y offset is negative
    } flags_t;

    localparam int FLAGS_W = $bits(flags_t);

endpackage

### src/cbcr_front.sv
module cbcr_front #(
    parameter int CB = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [CB-1:0]         circle_x,
    input  logic [CB-1:0]         circle_y,
    input  logic [CB-2:0]         circle_radius,
    input  logic [CB-1:0]         box_x,
    input  logic [CB-1:0]         box_y,
    input  logic [CB-2:0]         box_width,
    input  logic [CB-2:0]         box_height,
    output logic                  out_valid,
    output cbcr_pkg::flags_t      flags,
    output logic [CB-1:0]         abs_x,
    output logic [CB-1:0]         abs_y,
    output logic [CB-1:0]         radius2,
    output logic [2*CB:0]         sum_sq
);

    localparam int EW = CB + 3;

    logic signed [EW-1:0] cx2, cy2, bx2, by2, wx, hy;
    logic signed [EW-1:0] lo_x, hi_x, lo_y, hi_y, near_x, near_y, d_x, d_y;

    logic signed [EW-1:0] dx_reg, dy_reg;
    logic [CB-1:0]        ra_reg;
    logic                 va_reg;

    logic [EW-1:0]        adx, ady;
    logic                 pre;
    logic [2*CB-1:0]      sqx_reg, sqy_reg;
    logic [CB-1:0]        axb_reg, ayb_reg, rb_reg;
    cbcr_pkg::flags_t     flb_reg, flb_next;
    logic                 vb_reg;

    logic [2*CB:0]        sum_reg;
    logic [CB-1:0]        axc_reg, ayc_reg, rc_reg;
    cbcr_pkg::flags_t     flc_reg;
    logic                 vc_reg;

    // Clamp the doubled centre to the doubled box extent
    always_comb
    begin
        cx2    = {{2{circle_x[CB-1]}}, circle_x, 1'b0};
        cy2    = {{2{circle_y[CB-1]}}, circle_y, 1'b0};
        bx2    = {{2{box_x[CB-1]}}, box_x, 1'b0};
        by2    = {{2{box_y[CB-1]}}, box_y, 1'b0};
        wx     = {4'b0, box_width};
        hy     = {4'b0, box_height};
        lo_x   = bx2 - wx;
        hi_x   = bx2 + wx;
        lo_y   = by2 - hy;
        hi_y   = by2 + hy;
        near_x = cx2;
        if (near_x > hi_x)
        begin
            near_x = hi_x;
        end
        if (near_x < lo_x)
        begin
            near_x = lo_x;
        end
        near_y = cy2;
        if (near_y > hi_y)
        begin
            near_y = hi_y;
        end
        if (near_y < lo_y)
        begin
            near_y = lo_y;
        end
        d_x = cx2 - near_x;
        d_y = cy2 - near_y;
    end

    // Magnitudes and range test ahead of the squares
    always_comb
    begin
        adx = dx_reg[EW-1] ? -dx_reg : dx_reg;
        ady = dy_reg[EW-1] ? -dy_reg : dy_reg;
        pre = (adx <= {3'b0, ra_reg}) && (ady <= {3'b0, ra_reg});
        flb_next.pre   = pre;
        flb_next.neg_x = dx_reg[EW-1];
        flb_next.neg_y = dy_reg[EW-1];
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    // Payload: offset, squares, sum
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg  <= d_x;
            dy_reg  <= d_y;
            ra_reg  <= {circle_radius, 1'b0};
            sqx_reg <= adx[CB-1:0] * adx[CB-1:0];
            sqy_reg <= ady[CB-1:0] * ady[CB-1:0];
            axb_reg <= adx[CB-1:0];
            ayb_reg <= ady[CB-1:0];
            rb_reg  <= ra_reg;
            flb_reg <= flb_next;
            sum_reg <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
            axc_reg <= axb_reg;
            ayc_reg <= ayb_reg;
            rc_reg  <= rb_reg;
            flc_reg <= flb_reg;
        end
    end

    assign out_valid = vc_reg;
    assign flags     = flc_reg;
    assign abs_x     = axc_reg;
    assign abs_y     = ayc_reg;
    assign radius2   = rc_reg;
    assign sum_sq    = sum_reg;

endmodule

### src/cbcr_sqrt.sv
module cbcr_sqrt #(
    parameter int CB = 24,
    parameter int SW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [2*CB:0]   radicand,
    input  logic [SW-1:0]   side_in,
    output logic            out_valid,
    output logic [CB:0]     root,
    output logic [SW-1:0]   side_out
);

    localparam int N    = CB + 1;
    localparam int RW   = CB + 3;
    localparam int RADW = 2 * CB + 2;

    logic [RW-1:0]   rem_q  [N+1];
    logic [CB:0]     root_q [N+1];
    logic [RADW-1:0] rad_q  [N+1];
    logic [SW-1:0]   side_q [N+1];
    logic            vld_q  [N+1];

    assign rem_q[0]  = '0;
    assign root_q[0] = '0;
    assign rad_q[0]  = {1'b0, radicand};
    assign side_q[0] = side_in;
    assign vld_q[0]  = in_valid;

    // One root bit per stage
    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic [RW-1:0] rem_t, trial;
        logic          ge;

        always_comb
        begin
            rem_t = {rem_q[i][RW-3:0], rad_q[i][RADW-1 -: 2]};
            trial = {root_q[i], 2'b01};
            ge    = rem_t >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_q[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_q[i+1] <= vld_q[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_q[i+1]  <= ge ? (rem_t - trial) : rem_t;
                root_q[i+1] <= {root_q[i][CB-1:0], ge};
                rad_q[i+1]  <= rad_q[i] << 2;
                side_q[i+1] <= side_q[i];
            end
        end
    end

    assign out_valid = vld_q[N];
    assign root      = root_q[N];
    assign side_out  = side_q[N];

endmodule

### src/cbcr_div.sv
module cbcr_div #(
    parameter int CB = 24,
    parameter int SW = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*CB-1:0]   num_x,
    input  logic [2*CB-1:0]   num_y,
    input  logic [CB:0]       den,
    input  logic [SW-1:0]     side_in,
    output logic              out_valid,
    output logic [CB-2:0]     quot_x,
    output logic [CB-2:0]     quot_y,
    output logic              sat_x,
    output logic              sat_y,
    output logic [SW-1:0]     side_out
);

    localparam int N = CB;

    logic [2*CB-1:0] rem_q  [N+1][2];
    logic [CB-2:0]   q_q    [N+1][2];
    logic            sat_q  [N+1][2];
    logic [CB:0]     den_q  [N+1];
    logic [SW-1:0]   side_q [N+1];
    logic            vld_q  [N+1];

    assign rem_q[0][0] = num_x;
    assign rem_q[0][1] = num_y;
    assign q_q[0][0]   = '0;
    assign q_q[0][1]   = '0;
    assign sat_q[0][0] = 1'b0;
    assign sat_q[0][1] = 1'b0;
    assign den_q[0]    = den;
    assign side_q[0]   = side_in;
    assign vld_q[0]    = in_valid;

    // First stage tests for overflow, the rest give one quotient bit each
    for (genvar j = 0; j < N; j++)
    begin : g_stage
        logic [2*CB-1:0] dsh;
        logic            ge [2];
        logic [2*CB-1:0] rem_n [2];
        logic [CB-2:0]   q_n [2];
        logic            sat_n [2];

        always_comb
        begin
            if (j == 0)
            begin
                dsh = {den_q[j], {(CB-1){1'b0}}};
            end
            else
            begin
                dsh = {{(CB-1){1'b0}}, den_q[j]} << (CB - 1 - j);
            end
            for (int l = 0; l < 2; l++)
            begin
                ge[l] = rem_q[j][l] >= dsh;
                if (j == 0)
                begin
                    rem_n[l] = rem_q[j][l];
                    q_n[l]   = q_q[j][l];
                    sat_n[l] = ge[l];
                end
                else
                begin
                    rem_n[l] = ge[l] ? (rem_q[j][l] - dsh) : rem_q[j][l];
                    q_n[l]   = {q_q[j][l][CB-3:0], ge[l]};
                    sat_n[l] = sat_q[j][l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_q[j+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_q[j+1] <= vld_q[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_q[j+1][0] <= rem_n[0];
                rem_q[j+1][1] <= rem_n[1];
                q_q[j+1][0]   <= q_n[0];
                q_q[j+1][1]   <= q_n[1];
                sat_q[j+1][0] <= sat_n[0];
                sat_q[j+1][1] <= sat_n[1];
                den_q[j+1]    <= den_q[j];
                side_q[j+1]   <= side_q[j];
            end
        end
    end

    assign out_valid = vld_q[N];
    assign quot_x    = q_q[N][0];
    assign quot_y    = q_q[N][1];
    assign sat_x     = sat_q[N][0];
    assign sat_y     = sat_q[N][1];
    assign side_out  = side_q[N];

endmodule

### src/circle_box_collision_resolve_core.sv
// Throughput: one word per cycle unless the output stalls; the bit-per-stage root and
// divider pipelines set the depth, not the rate. A stalled output holds the whole
// pipeline.
// Reset: rst_n clears all valid bits asynchronously; payload registers are not reset.
module circle_box_collision_resolve_core #(
    parameter int COORD_BITS = 24
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // circle_x, circle_y, circle_radius, box_x, box_y, box_width, box_height, zero pad
    input  logic [((7*COORD_BITS-3+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // hit, push_x, push_y, zero pad
    output logic [((2*COORD_BITS+1+7)/8)*8-1:0] m_axis_tdata
);

    localparam int CB    = COORD_BITS;
    localparam int OUT_W = ((2*CB+1+7)/8)*8;
    localparam int SSW   = cbcr_pkg::FLAGS_W + 3*CB;
    localparam int DSW   = 4;

    logic               en;
    logic               f_valid;
    cbcr_pkg::flags_t   f_flags;
    logic [CB-1:0]      f_ax, f_ay, f_r2;
    logic [2*CB:0]      f_sum;

    logic               s_valid;
    logic [CB:0]        s_root;
    logic [SSW-1:0]     s_side;
    cbcr_pkg::flags_t   s_flags;
    logic [CB-1:0]      s_ax, s_ay, s_r2;

    logic               hit, zero;
    logic [CB-1:0]      gap;
    logic               vm_reg;
    logic [2*CB-1:0]    mx_reg, my_reg;
    logic [CB:0]        den_reg;
    logic [DSW-1:0]     sm_reg, sm_next;

    logic               d_valid;
    logic [CB-2:0]      d_qx, d_qy;
    logic               d_sx, d_sy;
    logic [DSW-1:0]     d_side;
    logic [CB-1:0]      mag_x, mag_y, push_x, push_y;

    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg, out_data_next;

    // Advance everything whenever the output word can move on
    assign en            = m_axis_tready || !out_valid_reg;
    assign s_axis_tready = en;

    cbcr_front #(.CB(CB)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (s_axis_tvalid),
        .circle_x      (s_axis_tdata[CB-1:0]),
        .circle_y      (s_axis_tdata[2*CB-1:CB]),
        .circle_radius (s_axis_tdata[3*CB-2:2*CB]),
        .box_x         (s_axis_tdata[4*CB-2:3*CB-1]),
        .box_y         (s_axis_tdata[5*CB-2:4*CB-1]),
        .box_width     (s_axis_tdata[6*CB-3:5*CB-1]),
        .box_height    (s_axis_tdata[7*CB-4:6*CB-2]),
        .out_valid     (f_valid),
        .flags         (f_flags),
        .abs_x         (f_ax),
        .abs_y         (f_ay),
        .radius2       (f_r2),
        .sum_sq        (f_sum)
    );

    cbcr_sqrt #(.CB(CB), .SW(SSW)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .radicand  (f_sum),
        .side_in   ({f_flags, f_ax, f_ay, f_r2}),
        .out_valid (s_valid),
        .root      (s_root),
        .side_out  (s_side)
    );

    assign s_flags = s_side[SSW-1 -: cbcr_pkg::FLAGS_W];
    assign s_ax    = s_side[3*CB-1:2*CB];
    assign s_ay    = s_side[2*CB-1:CB];
    assign s_r2    = s_side[CB-1:0];

    // Hit test and the products offset times gap
    always_comb
    begin
        hit     = s_flags.pre && (s_root <= {1'b0, s_r2});
        zero    = !hit || (s_root == '0);
        gap     = s_r2 - s_root[CB-1:0];
        sm_next = {hit, zero, s_flags.neg_x, s_flags.neg_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
        end
        else if (en)
        begin
            vm_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg  <= s_ax * gap;
            my_reg  <= s_ay * gap;
            den_reg <= {s_root[CB-1:0], 1'b0};
            sm_reg  <= sm_next;
        end
    end

    cbcr_div #(.CB(CB), .SW(DSW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vm_reg),
        .num_x     (mx_reg),
        .num_y     (my_reg),
        .den       (den_reg),
        .side_in   (sm_reg),
        .out_valid (d_valid),
        .quot_x    (d_qx),
        .quot_y    (d_qy),
        .sat_x     (d_sx),
        .sat_y     (d_sy),
        .side_out  (d_side)
    );

    // Saturate, restore the sign and drop the vector on a miss or a zero-length offset
    always_comb
    begin
        mag_x  = d_sx ? {1'b0, {(CB-1){1'b1}}} : {1'b0, d_qx};
        mag_y  = d_sy ? {1'b0, {(CB-1){1'b1}}} : {1'b0, d_qy};
        push_x = d_side[2] ? '0 : (d_side[1] ? -mag_x : mag_x);
        push_y = d_side[2] ? '0 : (d_side[0] ? -mag_y : mag_y);
        out_data_next = '0;
        out_data_next[2*CB:0] = {push_y, push_x, d_side[3]};
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### bench/circle_box_collision_resolve_core_tb.sv
`timescale 1ns / 1ps

module circle_box_collision_resolve_core_tb;

    localparam int CB = 24;
    localparam int IN_W = ((7*CB-3+7)/8)*8;
    localparam int OUT_W = ((2*CB+1+7)/8)*8;
    localparam int LATENCY = 2*CB + 6;
    localparam int N_RANDOM = 450;
    localparam longint PUSH_MAX = (64'd1 << (CB-1)) - 1;
    localparam logic [CB-1:0] C_MAX = 24'h7fffff;
    localparam logic [CB-1:0] C_MIN = 24'h800000;
    localparam logic [CB-2:0] S_MAX = 23'h7fffff;

    typedef struct packed {
        logic [CB-2:0] box_height;
        logic [CB-2:0] box_width;
        logic [CB-1:0] box_y;
        logic [CB-1:0] box_x;
        logic [CB-2:0] circle_radius;
        logic [CB-1:0] circle_y;
        logic [CB-1:0] circle_x;
    } pair_t;

    typedef struct packed {
        logic [CB-1:0] push_y;
        logic [CB-1:0] push_x;
        logic          hit;
    } push_t;

    typedef struct {
        pair_t p;
        logic  known;
        push_t r;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    push_t pending_pushes[$];
    int errors = 0;
    int n_words_in = 0;
    int n_words_out = 0;
    int n_hits = 0;
    bit long_hold = 1'b0;

    circle_box_collision_resolve_core #(.COORD_BITS(CB)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // offset from the nearest point of the doubled-scale interval
    function automatic longint nearest_offset(longint pos, longint ctr, longint half);
        longint near;
        near = pos;
        if (near > ctr + half)
            near = ctr + half;
        if (near < ctr - half)
            near = ctr - half;
        return pos - near;
    endfunction

    function automatic logic [CB-1:0] push_part(longint d, longint unsigned gap,
                                                longint unsigned len);
        longint unsigned mag;
        longint unsigned q;
        mag = d < 0 ? longint'(-d) : d;
        q = (mag * gap) / (2 * len);
        if (q > PUSH_MAX)
            q = PUSH_MAX;
        return d < 0 ? CB'(-q) : CB'(q);
    endfunction

    function automatic push_t resolve_push(pair_t p);
        push_t r;
        longint dx;
        longint dy;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned r2;
        longint unsigned lim;
        longint unsigned len;
        r = '0;
        r2 = 2 * longint'(p.circle_radius);
        dx = nearest_offset(2 * longint'($signed(p.circle_x)),
                            2 * longint'($signed(p.box_x)), longint'(p.box_width));
        dy = nearest_offset(2 * longint'($signed(p.circle_y)),
                            2 * longint'($signed(p.box_y)), longint'(p.box_height));
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (ax <= r2 && ay <= r2)
        begin
            lim = (r2 + 1) * (r2 + 1);
            if (ax*ax < lim && ay*ay < lim - ax*ax)
            begin
                len = floor_root(ax*ax + ay*ay);
                r.hit = 1'b1;
                if (len != 0)
                begin
                    r.push_x = push_part(dx, r2 - len, len);
                    r.push_y = push_part(dy, r2 - len, len);
                end
            end
        end
        return r;
    endfunction

    function automatic pair_t mk(logic [CB-1:0] cx, logic [CB-1:0] cy, logic [CB-2:0] cr,
                                 logic [CB-1:0] bx, logic [CB-1:0] by,
                                 logic [CB-2:0] bw, logic [CB-2:0] bh);
        pair_t p;
        p.circle_x = cx; p.circle_y = cy; p.circle_radius = cr;
        p.box_x = bx; p.box_y = by; p.box_width = bw; p.box_height = bh;
        return p;
    endfunction

    // mostly near-contact pairs, with some wild ones and some narrow boxes
    function automatic pair_t random_pair();
        pair_t p;
        int sel;
        sel = $urandom_range(0, 9);
        p = pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        if (sel < 7)
        begin
            p.box_width = $urandom_range(0, 4000);
            p.box_height = $urandom_range(0, 4000);
            p.circle_radius = $urandom_range(0, 3000);
            p.circle_x = p.box_x + CB'($signed($urandom_range(0, 8000)) - 4000);
            p.circle_y = p.box_y + CB'($signed($urandom_range(0, 8000)) - 4000);
        end
        else if (sel < 8)
        begin
            p.circle_radius = $urandom_range(0, 4);
            p.box_width = $urandom_range(0, 3);
            p.circle_x = p.box_x + CB'($signed($urandom_range(0, 6)) - 3);
            p.circle_y = p.box_y + CB'($signed($urandom_range(0, 6)) - 3);
        end
        return p;
    endfunction

    task automatic send_pair(pair_t p);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_W'(p);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_pushes.push_back(resolve_push(p));
        n_words_in++;
    endtask

    task automatic idle_for(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // receiver stall pattern, plus one long hold on request
    initial
    begin
        int phase;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                m_axis_tready <= 1'b0;
                repeat (200) @(posedge clk);
                long_hold = 1'b0;
            end
            phase = (phase + 1) % 64;
            if (phase < 20)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // check each output word against the oldest prediction
    always @(posedge clk)
    begin
        push_t got;
        push_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = push_t'(m_axis_tdata[2*CB:0]);
            n_words_out++;
            if (got.hit)
                n_hits++;
            if (pending_pushes.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_pushes.pop_front();
                if (got.hit !== want.hit)
                begin
                    $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
                    errors++;
                end
                if (got.push_x !== want.push_x)
                begin
                    $display("%0t: push_x expected %h actual %h", $time,
                             want.push_x, got.push_x);
                    errors++;
                end
                if (got.push_y !== want.push_y)
                begin
                    $display("%0t: push_y expected %h actual %h", $time,
                             want.push_y, got.push_y);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        row_t rows[$];
        row_t rw;
        int burst;
        rows.push_back('{mk('0, '0, '0, '0, '0, '0, '0), 1'b1, push_t'({24'd0, 24'd0, 1'b1})});
        rows.push_back('{mk(C_MAX, C_MAX, '0, C_MIN, C_MIN, '0, '0), 1'b1, '0});
        rows.push_back('{mk(C_MIN, C_MIN, S_MAX, C_MAX, C_MAX, S_MAX, S_MAX), 1'b1, '0});
        rows.push_back('{mk(C_MAX, '0, S_MAX, C_MIN, '0, '0, '0), 1'b1, '0});
        rows.push_back('{mk(24'd100, '0, 23'd10, '0, '0, 23'd50, 23'd50), 1'b1, '0});
        rows.push_back('{mk(24'd200, 24'd5, S_MAX, '0, '0, 23'd0, 23'd0), 1'b0, '0});
        rows.push_back('{mk(24'd1, '0, S_MAX, '0, '0, 23'd1, 23'd0), 1'b0, '0});
        rows.push_back('{mk(-24'sd1, -24'sd1, S_MAX, '0, '0, '0, '0), 1'b0, '0});
        rows.push_back('{mk(24'd130, 24'd130, 23'd40, '0, '0, 23'd200, 23'd200), 1'b0, '0});
        rows.push_back('{mk(-24'sd140, 24'd0, 23'd40, '0, '0, 23'd200, 23'd200), 1'b0, '0});
        rows.push_back('{mk(24'd0, 24'd200, 23'd99, '0, '0, 23'd200, 23'd200), 1'b0, '0});
        rows.push_back('{mk(24'd0, -24'sd200, 23'd100, '0, '0, 23'd200, 23'd200), 1'b0, '0});
        rows.push_back('{mk(24'd10, 24'd10, 23'd14, '0, '0, '0, '0), 1'b0, '0});
        rows.push_back('{mk(24'h555555, 24'haaaaaa, 23'h2aaaaa, 24'haaaaaa, 24'h555555,
                            23'h555555, 23'h2aaaaa), 1'b0, '0});
        rows.push_back('{mk('0, '0, S_MAX, 24'd1, '0, '0, '0), 1'b0, '0});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (rows[i])
        begin
            rw = rows[i];
            if (rw.known && resolve_push(rw.p) !== rw.r)
            begin
                $display("%0t: table row %0d expected %h actual %h", $time, i,
                         rw.r, resolve_push(rw.p));
                errors++;
            end
            send_pair(rw.p);
        end

        // hold until drained
        s_axis_tvalid <= 1'b0;
        while (pending_pushes.size() != 0)
            @(posedge clk);

        // long receiver hold while offering back to back
        long_hold = 1'b1;
        repeat (120) send_pair(random_pair());

        // random bursts with gaps
        while (n_words_in < N_RANDOM + rows.size())
        begin
            burst = $urandom_range(1, 20);
            repeat (burst) send_pair(random_pair());
            if ($urandom_range(0, 2) != 0)
                idle_for($urandom_range(1, 8));
        end
        s_axis_tvalid <= 1'b0;

        while (pending_pushes.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("Sent %0d pairs, checked %0d words, %0d of them hits.",
                 n_words_in, n_words_out, n_hits);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
